// ===== rtl/kesp_pkg.sv =====
// Shared widths and character codes for the key escape sequence parser.
`timescale 1ns / 1ps
package kesp_pkg;

  localparam int ByteW = 8;
  localparam int SymW  = 24;

  localparam logic [ByteW-1:0] ChEsc   = 8'd31;
  localparam logic [ByteW-1:0] ChN     = 8'h4E;
  localparam logic [ByteW-1:0] ChS     = 8'h53;
  localparam logic [ByteW-1:0] ChO     = 8'h4F;
  localparam logic [ByteW-1:0] ChK     = 8'h4B;
  localparam logic [ByteW-1:0] ChUnder = 8'h5F;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] Ch0     = 8'h30;
  localparam logic [ByteW-1:0] Ch9     = 8'h39;
  localparam logic [ByteW-1:0] ChA     = 8'h41;
  localparam logic [ByteW-1:0] ChF     = 8'h46;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } kesp_item_t;

endpackage

// ===== rtl/key_escape_sequence_parser_unit.sv =====
// Top level of the key escape sequence parser.
// The last byte of a message is held in the byte register; the result is registered when the parser takes it.
// Throughput: one byte per cycle; only a last byte waits in the byte register, and only
// while the result register is full and not taken.
// Reset: synchronous rst empties both registers and returns the parser to the
// start of a message.
`timescale 1ns / 1ps
module key_escape_sequence_parser_unit
  import kesp_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [ByteW-1:0] data_byte,
  input  logic            end_of_message,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            symbol_valid,
  output logic [SymW-1:0] symbol
);

  logic       item_valid;
  logic       item_take;
  kesp_item_t item;

  kesp_in_reg u_in_reg (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take)
  );

  kesp_parser #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_valid (symbol_valid),
    .symbol       (symbol)
  );

endmodule

// ===== rtl/kesp_in_reg.sv =====
// Input register stage that holds one byte transaction ahead of the parser.
`timescale 1ns / 1ps
module kesp_in_reg
  import kesp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  input  logic             end_of_message,
  output logic             item_valid,
  output kesp_item_t       item,
  input  logic             item_take
);

  logic       held;
  kesp_item_t held_item;

  assign in_ready   = !held || item_take;
  assign item_valid = held;
  assign item       = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_item.data <= data_byte;
      held_item.last <= end_of_message;
    end
  end

endmodule

// ===== rtl/kesp_parser.sv =====
// Parse state, digit accumulator and the result register.
`timescale 1ns / 1ps
module kesp_parser
  import kesp_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  kesp_item_t      item,
  output logic            item_take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            symbol_valid,
  output logic [SymW-1:0] symbol
);

  localparam int CntW = $clog2(MAX_HEX_DIGITS + 1);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_MODS,
    PH_AFTERK,
    PH_DIGITS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t          phase, phase_next;
  logic [SymW-1:0] acc, acc_next;
  logic [CntW-1:0] count, count_next;
  logic            is_hex;
  logic [3:0]      hex_val;
  logic [ByteW-1:0] c;

  assign c = item.data;
  assign item_take = item_valid && (!item.last || !out_valid || out_ready);

  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (c >= Ch0 && c <= Ch9) begin
      is_hex  = 1'b1;
      hex_val = 4'(c - Ch0);
    end else if (c >= ChA && c <= ChF) begin
      is_hex  = 1'b1;
      hex_val = 4'(c - ChA + 8'd10);
    end
  end

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    count_next = count;
    case (phase)
      PH_FIRST: begin
        phase_next = (c == ChEsc) ? PH_MODS : PH_ERROR;
      end
      PH_MODS: begin
        if (c == ChN || c == ChS || c == ChO) begin
          phase_next = PH_MODS;
        end else if (c == ChK) begin
          phase_next = PH_AFTERK;
        end else if (c == ChUnder) begin
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_AFTERK: begin
        phase_next = (c == ChUnder) ? PH_DIGITS : PH_ERROR;
      end
      PH_DIGITS: begin
        if (c == ChCr) begin
          phase_next = (count != '0) ? PH_DONE : PH_ERROR;
        end else if (!is_hex || count >= CntW'(MAX_HEX_DIGITS)) begin
          phase_next = PH_ERROR;
        end else begin
          count_next = count + 1'b1;
          acc_next   = {acc[SymW-5:0], hex_val};
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      acc       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (item_take && item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (item_take) begin
        if (item.last) begin
          phase     <= PH_FIRST;
          acc       <= '0;
          count     <= '0;
          if (phase == PH_FIRST) begin
            symbol_valid <= 1'b1;
            symbol       <= SymW'(c);
          end else if (phase_next == PH_DONE) begin
            symbol_valid <= 1'b1;
            symbol       <= acc_next;
          end else begin
            symbol_valid <= 1'b0;
            symbol       <= '0;
          end
        end else begin
          phase <= phase_next;
          acc   <= acc_next;
          count <= count_next;
        end
      end
    end
  end

endmodule

// ===== dv/key_escape_sequence_parser_unit_tb.sv =====
// Self-checking testbench for the key escape sequence parser, with directed and random messages.
`timescale 1ns / 1ps
module key_escape_sequence_parser_unit_tb;
  import kesp_pkg::*;

  localparam int MaxHexDigits = 6;
  localparam int RandomBytes  = 1650;
  localparam logic [ByteW-1:0] ChLowA = 8'h61;

  typedef enum logic [2:0] {
    ST_FIRST, ST_MODS, ST_AFTER_K, ST_DIGITS, ST_DONE, ST_ERROR
  } parse_phase_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic            ok;
    logic [SymW-1:0] sym;
  } key_symbol_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             typed;
    key_symbol_t      res;
  } key_row_t;

  localparam int DirRows = 27;
  localparam key_row_t KeyRows [DirRows] = '{
    '{8'h00,   1'b1, 1'b1, '{1'b1, 24'h000000}},
    '{8'hFF,   1'b1, 1'b1, '{1'b1, 24'h0000FF}},
    '{ChEsc,   1'b1, 1'b1, '{1'b1, 24'h00001F}},
    '{ChEsc,   1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChN,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChS,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChO,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChK,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChUnder, 1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChF,     1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChCr,    1'b1, 1'b1, '{1'b1, 24'hFFFFFF}},
    '{ChEsc,   1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChUnder, 1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChCr,    1'b1, 1'b1, '{1'b0, 24'h000000}},
    '{ChEsc,   1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChUnder, 1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChLowA,  1'b1, 1'b1, '{1'b0, 24'h000000}},
    '{ChEsc,   1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChUnder, 1'b0, 1'b0, '{1'b0, 24'h0}},
    '{8'h37,   1'b0, 1'b0, '{1'b0, 24'h0}},
    '{ChCr,    1'b0, 1'b0, '{1'b0, 24'h0}},
    '{8'h51,   1'b1, 1'b0, '{1'b0, 24'h0}}
  };

  localparam logic [ByteW-1:0] ModChars [3] = '{ChN, ChS, ChO};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] data_byte = '0;
  logic             end_of_message = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             symbol_valid;
  logic [SymW-1:0]  symbol;

  parse_phase_t     parse_st = ST_FIRST;
  logic [SymW-1:0]  acc_sym = '0;
  int               digit_cnt = 0;
  key_symbol_t      expected_symbols[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int symbols_checked = 0;
  int symbols_ok = 0;
  int burst_left = 0;

  rx_mode_t   stall_mode = RX_ALWAYS;
  int         stall_left = 0;
  logic [7:0] stall_mask = 8'h01;

  key_escape_sequence_parser_unit #(
    .MAX_HEX_DIGITS(MaxHexDigits)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .symbol_valid   (symbol_valid),
    .symbol         (symbol)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit decode_key_byte(input logic [ByteW-1:0] ch, input logic last,
                                         output key_symbol_t res);
    logic [4:0] hex;
    bit         at_first;
    at_first = (parse_st == ST_FIRST);
    res = '0;
    if (at_first) begin
      parse_st = (ch == ChEsc) ? ST_MODS : ST_ERROR;
    end else begin
      case (parse_st)
        ST_MODS: begin
          if (ch == ChK) parse_st = ST_AFTER_K;
          else if (ch == ChUnder) parse_st = ST_DIGITS;
          else if (!(ch == ChN || ch == ChS || ch == ChO)) parse_st = ST_ERROR;
        end
        ST_AFTER_K: parse_st = (ch == ChUnder) ? ST_DIGITS : ST_ERROR;
        ST_DIGITS: begin
          if (ch == ChCr) begin
            parse_st = (digit_cnt != 0) ? ST_DONE : ST_ERROR;
          end else begin
            if (ch >= Ch0 && ch <= Ch9) hex = 5'(ch - Ch0);
            else if (ch >= ChA && ch <= ChF) hex = 5'(ch - ChA + 8'd10);
            else hex = 5'd16;
            if (hex == 5'd16 || digit_cnt >= MaxHexDigits) begin
              parse_st = ST_ERROR;
            end else begin
              digit_cnt++;
              acc_sym = {acc_sym[SymW-5:0], hex[3:0]};
            end
          end
        end
        ST_DONE: ;
        default: parse_st = ST_ERROR;
      endcase
    end
    if (!last) return 1'b0;
    if (at_first) res = '{1'b1, {{(SymW-ByteW){1'b0}}, ch}};
    else if (parse_st == ST_DONE) res = '{1'b1, acc_sym};
    parse_st  = ST_FIRST;
    acc_sym   = '0;
    digit_cnt = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  // One transaction on the byte channel, with the sender's burst and gap pattern in front of it.
  task automatic send_key_byte(input logic [ByteW-1:0] ch, input logic last, input bit typed,
                               input key_symbol_t typed_res);
    int          gap;
    key_symbol_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_byte      <= ch;
    end_of_message <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) msgs_sent++;
    if (decode_key_byte(ch, last, res)) expected_symbols.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_symbols();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_symbols.size() != 0);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(16, 160);
      stall_mask <= 8'($urandom_range(1, 255));
    end else begin
      stall_left <= stall_left - 1;
      stall_mask <= {stall_mask[6:0], stall_mask[7]};
    end
    case (stall_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= stall_mask[0];
    endcase
  end

  always @(posedge clk) begin
    key_symbol_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: valid=%0b symbol=%06h",
                                  symbol_valid, symbol));
      end else begin
        want = expected_symbols.pop_front();
        symbols_checked++;
        if (want.ok) symbols_ok++;
        if (symbol_valid !== want.ok)
          report_mismatch($sformatf("symbol_valid %0b, expected %0b", symbol_valid, want.ok));
        if (symbol !== want.sym)
          report_mismatch($sformatf("symbol %06h, expected %06h", symbol, want.sym));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("key_escape_sequence_parser_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic [ByteW-1:0] msg[$];
    int               kind;
    int               ndig;
    int               hex;
    int               cut;
    int               rand_bytes;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++)
      send_key_byte(KeyRows[i].data, KeyRows[i].last, KeyRows[i].typed, KeyRows[i].res);
    drain_symbols();

    rand_bytes = 0;
    while (rand_bytes < RandomBytes) begin
      msg.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        msg.push_back(8'($urandom));
      end else if (kind < 20) begin
        msg.push_back(($urandom_range(0, 1) != 0) ? ChEsc : 8'($urandom));
        repeat ($urandom_range(1, 7)) msg.push_back(8'($urandom));
      end else begin
        msg.push_back(ChEsc);
        repeat ($urandom_range(0, 3)) msg.push_back(ModChars[$urandom_range(0, 2)]);
        if ($urandom_range(0, 1) != 0) msg.push_back(ChK);
        msg.push_back(ChUnder);
        case ($urandom_range(0, 9))
          0: ndig = 0;
          1: ndig = MaxHexDigits + 1;
          default: ndig = $urandom_range(1, MaxHexDigits);
        endcase
        repeat (ndig) begin
          hex = $urandom_range(0, 15);
          msg.push_back((hex < 10) ? Ch0 + 8'(hex) : ChA + 8'(hex - 10));
        end
        msg.push_back(ChCr);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom));
        if (kind >= 80) begin
          if ($urandom_range(0, 1) != 0) begin
            msg[$urandom_range(1, msg.size() - 1)] = ($urandom_range(0, 1) != 0) ?
                8'($urandom) : ChLowA + 8'($urandom_range(0, 5));
          end else begin
            cut = $urandom_range(2, msg.size() - 1);
            while (msg.size() > cut) void'(msg.pop_back());
          end
        end
      end
      foreach (msg[i]) send_key_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
      rand_bytes += msg.size();
      if ($urandom_range(0, 39) == 0) drain_symbols();
    end

    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d messages in %0d bytes; checked %0d symbols (%0d parsed, %0d malformed).",
             msgs_sent, bytes_sent, symbols_checked, symbols_ok, symbols_checked - symbols_ok);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("key_escape_sequence_parser_unit_tb: PASS");
    end else begin
      $display("key_escape_sequence_parser_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== key_escape_sequence_parser_unit.f =====
rtl/kesp_pkg.sv
rtl/kesp_in_reg.sv
rtl/kesp_parser.sv
rtl/key_escape_sequence_parser_unit.sv
dv/key_escape_sequence_parser_unit_tb.sv
